### rtl/dma_pkg.sv
`timescale 1ns / 1ps
package dma_pkg;
	localparam int FracBits = 52;
	localparam int ExpBits = 11;
	localparam int MagBits = 63;
	localparam int WideBits = 57;
	localparam logic [ExpBits-1:0] ExpMax = 11'h7ff;
	localparam logic [MagBits-1:0] InfBits = {ExpMax, {FracBits{1'b0}}};
	localparam int GapLimit = 56;
endpackage

### rtl/dma_align.sv
`timescale 1ns / 1ps
module dma_align import dma_pkg::*; (
	input  logic [FracBits:0]  mb,
	input  logic [ExpBits-1:0] gap,
	output logic [WideBits-1:0] wb
);
	logic [WideBits-1:0] ext;
	logic [WideBits-1:0] mask;
	logic [WideBits-1:0] shifted;
	logic                lost;

	always_comb begin
		ext = {1'b0, mb, 3'b000};
		mask = ({WideBits{1'b1}} << gap[5:0]);
		shifted = ext >> gap[5:0];
		lost = |(ext & ~mask);
		if (gap >= ExpBits'(GapLimit)) begin
			wb = {{(WideBits-1){1'b0}}, |mb};
		end else begin
			wb = shifted | {{(WideBits-1){1'b0}}, lost};
		end
	end
endmodule

### rtl/double_magnitude_adder.sv
`timescale 1ns / 1ps
// four register stages (s1 to s4) lie between input transfer and the result on the output port
// throughput: one operand pair per cycle while the output is not stalled, set by the four-stage pipeline
// a stalled output holds every stage; nothing is lost or repeated
// reset: arst_n clears all stage valid bits asynchronously
// payload registers are not reset
module double_magnitude_adder import dma_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] sum_bits,
	output logic        special_input
);
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: swap and unpack
	logic [MagBits-1:0] a_c, b_c, big_c, sml_c;
	logic               sp_c;
	logic [ExpBits-1:0] ea_s1, gap_s1;
	logic [FracBits:0]  ma_s1, mb_s1;
	logic               sp_s1;
	logic [ExpBits-1:0] ea_c, eb_c;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_comb begin
		a_c = operand_a[MagBits-1:0];
		b_c = operand_b[MagBits-1:0];
		sp_c = (a_c[MagBits-1:FracBits] == ExpMax) || (b_c[MagBits-1:FracBits] == ExpMax);
		big_c = (a_c < b_c) ? b_c : a_c;
		sml_c = (a_c < b_c) ? a_c : b_c;
		ea_c = (big_c[MagBits-1:FracBits] == '0) ? ExpBits'(1) : big_c[MagBits-1:FracBits];
		eb_c = (sml_c[MagBits-1:FracBits] == '0) ? ExpBits'(1) : sml_c[MagBits-1:FracBits];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ea_s1 <= ea_c;
			gap_s1 <= ea_c - eb_c;
			ma_s1 <= {big_c[MagBits-1:FracBits] != '0, big_c[FracBits-1:0]};
			mb_s1 <= {sml_c[MagBits-1:FracBits] != '0, sml_c[FracBits-1:0]};
			sp_s1 <= sp_c;
		end
	end

	// stage 2: align and add
	logic [WideBits-1:0] wb_c, sum_c;
	logic [WideBits-1:0] wa_s2;
	logic [ExpBits-1:0]  ea_s2;
	logic                sp_s2;

	dma_align u_align (
		.mb  (mb_s1),
		.gap (gap_s1),
		.wb  (wb_c)
	);

	assign sum_c = {1'b0, ma_s1, 3'b000} + wb_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s2 <= sum_c;
			ea_s2 <= ea_s1;
			sp_s2 <= sp_s1;
		end
	end

	// stage 3: normalize and round
	logic [WideBits-1:0] wn_c;
	logic [ExpBits:0]    en_c;
	logic [FracBits+1:0] m_c;
	logic [2:0]          rem_c;
	logic                up_c;
	logic [FracBits+1:0] m_s3;
	logic                up_s3;
	logic [ExpBits:0]    e_s3;
	logic                sp_s3;

	always_comb begin
		if (wa_s2[WideBits-1]) begin
			wn_c = (wa_s2 >> 1) | {{(WideBits-1){1'b0}}, wa_s2[0]};
			en_c = {1'b0, ea_s2} + 1'b1;
		end else begin
			wn_c = wa_s2;
			en_c = {1'b0, ea_s2};
		end
		m_c = {1'b0, wn_c[WideBits-2:3]};
		rem_c = wn_c[2:0];
		up_c = (rem_c > 3'd4) || (rem_c == 3'd4 && m_c[0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3 <= m_c;
			up_s3 <= up_c;
			e_s3 <= en_c - 1'b1;
			sp_s3 <= sp_s2;
		end
	end

	// stage 4: pack and saturate, zero result on special input
	logic [MagBits:0] res_c;
	logic [62:0]      sum_s4;
	logic             sp_s4;

	always_comb begin
		res_c = ({{(MagBits+1-ExpBits-1){1'b0}}, e_s3} << FracBits)
			+ {{(MagBits+1-FracBits-2){1'b0}}, m_s3} + {{MagBits{1'b0}}, up_s3};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s4 <= sp_s3;
			if (sp_s3) begin
				sum_s4 <= '0;
			end else if (res_c >= {1'b0, InfBits}) begin
				sum_s4 <= InfBits;
			end else begin
				sum_s4 <= res_c[MagBits-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
	assign sum_bits = sum_s4;
	assign special_input = sp_s4;
endmodule

### verif/double_magnitude_adder_test.sv
`timescale 1ns / 1ps
module double_magnitude_adder_test;
	import dma_pkg::*;

	typedef struct packed {
		logic [62:0] sum_bits;
		logic        special_input;
	} sum_result_t;

	class sum_scoreboard;
		sum_result_t pending[$];
		int errors;

		// rounded magnitude sum, nearest even
		function sum_result_t predict(logic [63:0] x, logic [63:0] y);
			sum_result_t r;
			logic [62:0] a, b, t, res;
			logic [10:0] ea0, eb0;
			logic [63:0] ea, eb, ma, mb, wa, wb, m, rem, gap, lost;
			a = x[62:0];
			b = y[62:0];
			r.sum_bits = '0;
			r.special_input = 1'b0;
			if (a[62:52] == ExpMax || b[62:52] == ExpMax) begin
				r.special_input = 1'b1;
				return r;
			end
			if (a < b) begin
				t = a;
				a = b;
				b = t;
			end
			ea0 = a[62:52];
			eb0 = b[62:52];
			ma = {12'd0, a[51:0]};
			mb = {12'd0, b[51:0]};
			ea = 64'(ea0);
			eb = 64'(eb0);
			if (ea0 != 0) ma[52] = 1'b1; else ea = 1;
			if (eb0 != 0) mb[52] = 1'b1; else eb = 1;
			wa = ma << 3;
			wb = mb << 3;
			gap = ea - eb;
			if (gap >= GapLimit) begin
				wb = (mb != 0) ? 64'd1 : 64'd0;
			end else if (gap > 0) begin
				lost = wb & ((64'd1 << gap) - 64'd1);
				wb = (wb >> gap) | ((lost != 0) ? 64'd1 : 64'd0);
			end
			wa = wa + wb;
			if (wa[56]) begin
				wa = (wa >> 1) | (wa & 64'd1);
				ea = ea + 1;
			end
			m = wa >> 3;
			rem = wa & 64'd7;
			if (rem > 4 || (rem == 4 && m[0]))
				m = m + 1;
			ea = ((ea - 1) << 52) + m;
			res = ea[62:0];
			if (ea >= {1'b0, InfBits})
				res = InfBits;
			r.sum_bits = res;
			return r;
		endfunction

		function void note_operands(logic [63:0] x, logic [63:0] y);
			pending.push_back(predict(x, y));
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		task check_result(logic [62:0] s, logic sp);
			sum_result_t e;
			if (pending.size() == 0) begin
				report("unexpected transfer", {sp, s}, 0);
				return;
			end
			e = pending.pop_front();
			if (s !== e.sum_bits) report("sum_bits", s, e.sum_bits);
			if (sp !== e.special_input) report("special_input", sp, e.special_input);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [63:0] operand_a = 0;
	logic [63:0] operand_b = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [62:0] sum_bits;
	logic        special_input;

	sum_scoreboard sb = new();
	int cycles = 0;
	bit calm = 0;
	bit hold_off = 0;
	bit sending_done = 0;

	double_magnitude_adder i_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("double_magnitude_adder_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_operands(operand_a, operand_b);
		if (out_valid && out_ready) sb.check_result(sum_bits, special_input);
	end

	function logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random double biased toward interesting exponents and mantissas
	function logic [63:0] rand_double();
		logic [63:0] v;
		v = rand64();
		case ($urandom_range(0, 7))
			0: v[62:52] = 0;
			1: v[62:52] = ExpMax;
			2: v[62:52] = ExpMax - 11'd1;
			3: v[62:52] = 11'($urandom_range(0, 3));
			4: v[51:0] = $urandom_range(0, 1) ? '0 : '1;
			default: ;
		endcase
		return v;
	endfunction

	task send(logic [63:0] x, logic [63:0] y);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		operand_a <= x;
		operand_b <= y;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// related pair: b near a in exponent
	task send_near();
		logic [63:0] x, y;
		x = rand_double();
		y = rand64();
		y[62:52] = x[62:52] - 11'($urandom_range(0, 60));
		if (y[62:52] == ExpMax) y[62:52] = 0;
		send(x, y);
	endtask

	always @(negedge clk) begin
		if (hold_off || !arst_n) out_ready <= 0;
		else if (!calm && $urandom_range(0, 4) == 0) out_ready <= 0;
		else out_ready <= 1;
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send(0, 0);
		send(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
		send(64'h7ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
		send(64'h3ff0_0000_0000_0000, 64'hfff8_0000_0000_0001);
		send(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		send(64'h7fef_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff);
		send(64'h7fef_ffff_ffff_ffff, 64'h7ca0_0000_0000_0000);
		send(64'h000f_ffff_ffff_ffff, 64'h0000_0000_0000_0001);
		send(64'h000f_ffff_ffff_ffff, 64'h800f_ffff_ffff_ffff);
		send(64'h3ff0_0000_0000_0000, 64'h3ca0_0000_0000_0000);
		send(64'h3ff0_0000_0000_0001, 64'h3ca0_0000_0000_0000);
		send(64'h3ff0_0000_0000_0000, 64'h3ca0_0000_0000_0001);
		send(64'h3ff0_0000_0000_0000, 64'h3c80_0000_0000_0001);
		send(64'h4330_0000_0000_0000, 64'h0000_0000_0000_0001);
		send(64'h3ff0_0000_0000_0000, 64'h3fe0_0000_0000_0000);
		send(64'h3fff_ffff_ffff_ffff, 64'h3cb0_0000_0000_0000);
		send(64'h5555_5555_5555_5555, 64'h2aaa_aaaa_aaaa_aaaa);
		fork
			begin
				hold_off = 1;
				repeat (40) @(negedge clk);
				hold_off = 0;
			end
			repeat (20) send(rand_double(), rand_double());
		join
		for (int i = 0; i < 1260; i++) begin
			if (i == 1100) calm = 1;
			if ($urandom_range(0, 2) == 0) send(rand_double(), rand_double());
			else send_near();
		end
		in_valid <= 0;
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) $display("double_magnitude_adder_test passed");
		else $display("double_magnitude_adder_test failed");
		$finish;
	end
endmodule
